>>> hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the circular deque block.
// No dependencies; every other file refers to it by scoped names.
package cdq_pkg;

  localparam int CAP_W    = 5;   // width of the capacity configuration data
  localparam int CAP_RST  = 16;  // capacity after reset, before saturation
  localparam int CMD_W    = 3;
  localparam int RESULT_W = 16;  // width of the front and rear result fields

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_NOP        = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_READ = 2'd2,
    ST_RESP = 2'd3
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the incoming transaction
    logic clear;  // capacity write: take new capacity, empty the queue
    logic exec;   // apply the captured command to pointers and store
    logic read;   // read front and rear entries of the ring store
  } dp_cmd_t;

endpackage

>>> hw/rtl/cdq_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the circular deque: request, response, configuration.
// Uses cdq_pkg for field widths.
interface cdq_req_if #(parameter int DATA_BITS = 15);
  logic                        valid;
  logic                        ready;
  logic [cdq_pkg::CMD_W-1:0]   cmd;
  logic [DATA_BITS-1:0]        value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface cdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic signed [cdq_pkg::RESULT_W-1:0] front_value;
  logic signed [cdq_pkg::RESULT_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;
  modport source (output valid, output accepted, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input accepted, input front_value, input rear_value,
                input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [cdq_pkg::CAP_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/circular_deque.sv
`timescale 1ns / 1ps
// Circular deque top level: each request transaction passes through an execute
// step and a registered two-port read of the ring store before its result is
// valid. One request is in flight at a time; a new one is taken at the earliest
// the cycle after the result transaction.
// Reset (synchronous) empties the queue and sets capacity to 16, or DEPTH if
// smaller; the ring store itself is not cleared.
module circular_deque #(
  parameter int DEPTH     = 16,
  parameter int DATA_BITS = 15
) (
  input  logic      clk,
  input  logic      rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp,
  cdq_cfg_if.sink   cfg
);

  cdq_pkg::dp_cmd_t dp_cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .dp_cmd    (dp_cmd)
  );

  cdq_dpath #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .req_cmd     (req.cmd),
    .req_value   (req.value),
    .cfg_data    (cfg.data),
    .accepted    (rsp.accepted),
    .front_value (rsp.front_value),
    .rear_value  (rsp.rear_value),
    .is_empty    (rsp.is_empty),
    .is_full     (rsp.is_full)
  );

endmodule

>>> hw/rtl/cdq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the circular deque: takes configuration writes and sequences capture, execute, read, respond.
// Depends on cdq_pkg for the state and command types.
module cdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output cdq_pkg::dp_cmd_t dp_cmd
);

  cdq_pkg::state_t state;
  cdq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cfg_ready  = 1'b0;
    rsp_valid  = 1'b0;
    dp_cmd     = '0;
    case (state)
      cdq_pkg::ST_IDLE: begin
        // configuration wins a tie with a request
        cfg_ready = 1'b1;
        req_ready = !cfg_valid;
        if (cfg_valid) begin
          dp_cmd.clear = 1'b1;
        end else if (req_valid) begin
          dp_cmd.load = 1'b1;
          state_next  = cdq_pkg::ST_EXEC;
        end
      end
      cdq_pkg::ST_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_next  = cdq_pkg::ST_READ;
      end
      cdq_pkg::ST_READ: begin
        dp_cmd.read = 1'b1;
        state_next  = cdq_pkg::ST_RESP;
      end
      cdq_pkg::ST_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = cdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/cdq_dpath.sv
`timescale 1ns / 1ps
// Datapath of the circular deque: pointers, empty flag, capacity, ring store.
// Depends on cdq_pkg; driven by cdq_ctrl through dp_cmd_t.
module cdq_dpath #(
  parameter int DEPTH     = 16,
  parameter int DATA_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cdq_pkg::dp_cmd_t                    dp_cmd,
  input  logic [cdq_pkg::CMD_W-1:0]           req_cmd,
  input  logic [DATA_BITS-1:0]                req_value,
  input  logic [cdq_pkg::CAP_W-1:0]           cfg_data,
  output logic                                accepted,
  output logic signed [cdq_pkg::RESULT_W-1:0] front_value,
  output logic signed [cdq_pkg::RESULT_W-1:0] rear_value,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = (IW + 1 > cdq_pkg::CAP_W) ? IW + 1 : cdq_pkg::CAP_W;
  localparam int RST_CAP = (DEPTH < cdq_pkg::CAP_RST) ? DEPTH : cdq_pkg::CAP_RST;
  localparam logic [CW-1:0] DEPTH_W  = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_MAX = IW'(DEPTH - 1);
  localparam logic [IW-1:0] LAST_RST = IW'(RST_CAP - 1);

  logic [DATA_BITS-1:0] mem [DEPTH];

  cdq_pkg::cmd_t        op;
  logic [DATA_BITS-1:0] val;
  logic [IW-1:0]        head;
  logic [IW-1:0]        tail;
  logic [IW-1:0]        last;   // highest slot index in use (capacity - 1)
  logic                 empty;
  logic                 ok;
  logic [DATA_BITS-1:0] rd_front;
  logic [DATA_BITS-1:0] rd_rear;

  logic [IW-1:0] head_next;
  logic [IW-1:0] tail_next;
  logic          empty_next;
  logic          ok_next;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] head_dec;
  logic [IW-1:0] tail_inc;
  logic [IW-1:0] tail_dec;
  logic          full;
  logic [CW-1:0] cap_w;
  logic [IW-1:0] last_new;

  // wrap around the capacity in use
  assign head_inc = (head == last) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? last : head - 1'b1;
  assign tail_inc = (tail == last) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? last : tail - 1'b1;
  assign full     = !empty && (tail_inc == head);

  // zero capacity acts as one, anything above DEPTH saturates
  assign cap_w = CW'(cfg_data);
  always_comb begin
    if (cap_w == '0) begin
      last_new = '0;
    end else if (cap_w > DEPTH_W) begin
      last_new = LAST_MAX;
    end else begin
      last_new = IW'(cap_w - 1'b1);
    end
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    ok_next    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head;
    case (op)
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
        if (!full) begin
          ok_next = 1'b1;
          wr_en   = 1'b1;
          if (empty) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b0;
            wr_addr    = '0;
          end else if (op == cdq_pkg::CMD_PUSH_FRONT) begin
            head_next = head_dec;
            wr_addr   = head_dec;
          end else begin
            tail_next = tail_inc;
            wr_addr   = tail_inc;
          end
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
        if (!empty) begin
          ok_next = 1'b1;
          if (head == tail) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else if (op == cdq_pkg::CMD_POP_FRONT) begin
            head_next = head_inc;
          end else begin
            tail_next = tail_dec;
          end
        end
      end
      default: begin
        // no operation and unused codes leave the state alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
      last  <= LAST_RST;
      ok    <= 1'b0;
    end else if (dp_cmd.clear) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
      last  <= last_new;
    end else if (dp_cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
      ok    <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op  <= cdq_pkg::cmd_t'(req_cmd);
      val <= req_value;
    end
  end

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (dp_cmd.exec && wr_en) begin
      mem[wr_addr] <= val;
    end
    if (dp_cmd.read) begin
      rd_front <= mem[head];
      rd_rear  <= mem[tail];
    end
  end

  assign accepted    = ok;
  assign is_empty    = empty;
  assign is_full     = full;
  assign front_value = empty ? '1 : cdq_pkg::RESULT_W'(rd_front);
  assign rear_value  = empty ? '1 : cdq_pkg::RESULT_W'(rd_rear);

endmodule

>>> hw/rtl/cdq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the circular deque, bound onto circular_deque.
// Depends on cdq_pkg for field widths.
module cdq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [cdq_pkg::RESULT_W-1:0] front_value,
  input logic signed [cdq_pkg::RESULT_W-1:0] rear_value,
  input logic                                is_empty,
  input logic                                is_full
);

  // a pending result holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before its transaction");

  // no new request while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(req_valid && req_ready))
    else $error("request taken while a result is pending");

  // fixed latency from request to result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##3 rsp_valid)
    else $error("result not valid three cycles after request");

  // an empty queue shows -1 at both ends and is never full
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> front_value == '1 && rear_value == '1 && !is_full)
    else $error("empty result with bad values or full flag");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .front_value (rsp.front_value),
  .rear_value  (rsp.rear_value),
  .is_empty    (rsp.is_empty),
  .is_full     (rsp.is_full)
);
